// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle whenever ante holds.
`define PIR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Check that cons holds in the cycle after ante holds.
`define PIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`else

`define PIR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PIR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/pir_pkg.sv
// ----------------------------------------------------------------------------
// pir_pkg
// Shared types and fixed constants of the pixel integer rescaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pir_pkg;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_WIDTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE_MODE   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE_FACTOR = 2'd2;

    // Register field widths
    localparam int SRC_WIDTH_W = 13;
    localparam int FACTOR_W    = 5;

    // Scale mode codes
    localparam logic MODE_ENLARGE = 1'b0;
    localparam logic MODE_SHRINK  = 1'b1;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // Per-request emit job: what every copy carries
    typedef struct packed {
        pixel_t     pix;
        logic       row_end;
        logic [1:0] pad;
    } job_info_t;

    // One result request
    typedef struct packed {
        pixel_t     pix;
        logic       row_end;
        logic [1:0] pad;
        logic       last;
    } result_t;

endpackage

// File: rtl/pir_intf.sv
// ----------------------------------------------------------------------------
// pir_intf
// Valid/ready channels of the rescaler: pixel in, pixel out, register write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pir_pix_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_start;

    modport source (output valid, output blue, output green, output red,
                    output frame_start, input ready);
    modport sink   (input valid, input blue, input green, input red,
                    input frame_start, output ready);
endinterface

interface pir_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       last;

    modport source (output valid, output out_blue, output out_green, output out_red,
                    output row_end, output pad_bytes, output last, input ready);
    modport sink   (input valid, input out_blue, input out_green, input out_red,
                    input row_end, input pad_bytes, input last, output ready);
endinterface

interface pir_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pir_pkg::CFG_ADDR_W-1:0] addr;
    logic [pir_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

// File: rtl/pir_cfg_regs.sv
// ----------------------------------------------------------------------------
// pir_cfg_regs
// Configuration registers and their clamped effective values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pir_cfg_regs #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_FACTOR = 16,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int FW = $clog2(MAX_FACTOR + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [pir_pkg::CFG_ADDR_W-1:0] wr_addr,
    input  logic [pir_pkg::CFG_DATA_W-1:0] wr_data,
    output logic [WW-1:0]                  eff_width,
    output logic [FW-1:0]                  eff_factor,
    output logic                           mode
);

    logic [pir_pkg::SRC_WIDTH_W-1:0] width_reg;
    logic                            mode_reg;
    logic [pir_pkg::FACTOR_W-1:0]    factor_reg;
    logic [31:0]                     width_raw;
    logic [31:0]                     factor_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= pir_pkg::SRC_WIDTH_W'(1);
            mode_reg   <= pir_pkg::MODE_ENLARGE;
            factor_reg <= pir_pkg::FACTOR_W'(1);
        end
        else if (wr_en)
        begin
            case (wr_addr)
                pir_pkg::REG_SOURCE_WIDTH: width_reg  <= wr_data[pir_pkg::SRC_WIDTH_W-1:0];
                pir_pkg::REG_SCALE_MODE:   mode_reg   <= wr_data[0];
                pir_pkg::REG_SCALE_FACTOR: factor_reg <= wr_data[pir_pkg::FACTOR_W-1:0];
                default:                   ; // drop writes to unmapped addresses
            endcase
        end
    end

    // Zero counts as one; saturate at the configured maxima.
    always_comb
    begin
        width_raw  = 32'(width_reg);
        factor_raw = 32'(factor_reg);
        if (width_raw == 32'd0)
            eff_width = WW'(1);
        else if (width_raw > 32'(MAX_WIDTH))
            eff_width = WW'(MAX_WIDTH);
        else
            eff_width = WW'(width_raw);
        if (factor_raw == 32'd0)
            eff_factor = FW'(1);
        else if (factor_raw > 32'(MAX_FACTOR))
            eff_factor = FW'(MAX_FACTOR);
        else
            eff_factor = FW'(factor_raw);
    end

    assign mode = mode_reg;

endmodule

// File: rtl/pir_ctrl.sv
// ----------------------------------------------------------------------------
// pir_ctrl
// Row/column bookkeeping; decides copy count, row end and pad per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pir_ctrl #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_FACTOR = 16,
    localparam int WW  = $clog2(MAX_WIDTH + 1),
    localparam int FW  = $clog2(MAX_FACTOR + 1),
    localparam int CW  = $clog2(MAX_WIDTH),
    localparam int PW  = $clog2(MAX_FACTOR),
    localparam int KW  = WW,
    localparam int XW  = WW + 1,
    localparam int PRW = KW + FW + 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  pir_pkg::pixel_t     pix,
    input  logic                frame_start,
    input  logic [WW-1:0]       eff_width,
    input  logic [FW-1:0]       eff_factor,
    input  logic                mode,
    output logic [FW-1:0]       copies,
    output pir_pkg::job_info_t  info
);

    logic [CW-1:0]  col_reg,  col_next,  col_cur;
    logic [PW-1:0]  rph_reg,  rph_next,  rph_cur;
    logic [PW-1:0]  cph_reg,  cph_next,  cph_cur;
    logic [KW-1:0]  kept_reg, kept_next, kept_cur;

    logic [CW:0]    col_inc;
    logic           row_last;
    logic [FW:0]    cph_inc;
    logic [FW:0]    rph_inc;
    logic [KW:0]    kept_inc;
    logic [PRW-1:0] prod;
    logic           keep;
    logic           rend_shrink;
    logic [3:0]     pad_prod;
    logic [1:0]     pad_enlarge;

    // A frame start clears every counter before this pixel is used.
    assign col_cur  = frame_start ? '0 : col_reg;
    assign rph_cur  = frame_start ? '0 : rph_reg;
    assign cph_cur  = frame_start ? '0 : cph_reg;
    assign kept_cur = frame_start ? '0 : kept_reg;

    assign col_inc  = (CW + 1)'(col_cur) + (CW + 1)'(1);
    assign row_last = XW'(col_inc) >= XW'(eff_width);
    assign cph_inc  = (FW + 1)'(cph_cur) + (FW + 1)'(1);
    assign rph_inc  = (FW + 1)'(rph_cur) + (FW + 1)'(1);
    assign kept_inc = (KW + 1)'(kept_cur) + (KW + 1)'(1);

    // kept < width/factor  <=>  (kept+1)*factor <= width
    // kept+1 >= width/factor  <=>  (kept+1)*factor + factor > width
    assign prod        = PRW'(kept_inc) * PRW'(eff_factor);
    assign keep        = (rph_cur == '0) && (cph_cur == '0) && (prod <= PRW'(eff_width));
    assign rend_shrink = (prod + PRW'(eff_factor)) > PRW'(eff_width);

    // Pad is (3*n) negated mod 4, which equals n mod 4.
    assign pad_prod    = {2'b00, eff_width[1:0]} * {2'b00, eff_factor[1:0]};
    assign pad_enlarge = pad_prod[1:0];

    always_comb
    begin
        info.pix  = pix;
        col_next  = col_cur;
        rph_next  = rph_cur;
        cph_next  = cph_cur;
        kept_next = kept_cur;
        if (mode == pir_pkg::MODE_SHRINK)
        begin
            copies       = keep ? FW'(1) : '0;
            info.row_end = rend_shrink;
            info.pad     = rend_shrink ? kept_inc[1:0] : 2'b00;
            if (row_last)
            begin
                col_next  = '0;
                cph_next  = '0;
                kept_next = '0;
                rph_next  = ((FW + 1)'(rph_inc) >= (FW + 1)'(eff_factor)) ? '0 : PW'(rph_inc);
            end
            else
            begin
                col_next  = CW'(col_inc);
                cph_next  = ((FW + 1)'(cph_inc) >= (FW + 1)'(eff_factor)) ? '0 : PW'(cph_inc);
                kept_next = keep ? KW'(kept_inc) : kept_cur;
            end
        end
        else
        begin
            copies       = eff_factor;
            info.row_end = row_last;
            info.pad     = row_last ? pad_enlarge : 2'b00;
            col_next     = row_last ? '0 : CW'(col_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            rph_reg  <= '0;
            cph_reg  <= '0;
            kept_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            rph_reg  <= rph_next;
            cph_reg  <= cph_next;
            kept_reg <= kept_next;
        end
    end

endmodule

// File: rtl/pir_emit.sv
// ----------------------------------------------------------------------------
// pir_emit
// Job register with copy counter feeding a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pir_emit #(
    parameter int MAX_FACTOR = 16,
    localparam int FW = $clog2(MAX_FACTOR + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [FW-1:0]      copies,
    input  pir_pkg::job_info_t info,
    output logic               in_ready,
    input  logic               out_ready,
    output logic               out_valid,
    output pir_pkg::result_t   out_data
);

    logic               job_valid_reg, job_valid_next;
    logic [FW-1:0]      left_reg, left_next;
    pir_pkg::job_info_t job_reg;
    logic               out_valid_reg, out_valid_next;
    pir_pkg::result_t   out_reg;

    logic               out_load;
    logic               emit;
    logic               final_copy;
    logic               job_done;
    logic               load_job;

    assign out_load   = !out_valid_reg || out_ready;
    assign emit       = job_valid_reg && out_load;
    assign final_copy = (left_reg == FW'(1));
    assign job_done   = emit && final_copy;
    assign in_ready   = !job_valid_reg || job_done;
    // Requests that make no result never occupy the job register.
    assign load_job   = in_valid && in_ready && (copies != '0);

    always_comb
    begin
        job_valid_next = job_valid_reg;
        left_next      = left_reg;
        if (load_job)
        begin
            job_valid_next = 1'b1;
            left_next      = copies;
        end
        else if (emit)
        begin
            job_valid_next = !final_copy;
            left_next      = left_reg - FW'(1);
        end
        out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_job)
            job_reg <= info;
        if (emit)
        begin
            out_reg.pix     <= job_reg.pix;
            out_reg.last    <= final_copy;
            out_reg.row_end <= final_copy && job_reg.row_end;
            out_reg.pad     <= (final_copy && job_reg.row_end) ? job_reg.pad : 2'b00;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `PIR_ASSERT_IMPLY(a_job_has_copies, clk, rst_n, job_valid_reg, left_reg != '0)
    `PIR_ASSERT_NEXT(a_job_loaded, clk, rst_n, load_job, job_valid_reg && (left_reg == $past(copies)))
    `PIR_ASSERT_IMPLY(a_row_end_is_last, clk, rst_n, out_valid_reg && out_reg.row_end, out_reg.last)
    `PIR_ASSERT_IMPLY(a_pad_at_row_end, clk, rst_n, out_valid_reg && (out_reg.pad != 2'b00), out_reg.row_end)

endmodule

// File: rtl/pixel_integer_rescaler_core.sv
// ----------------------------------------------------------------------------
// pixel_integer_rescaler_core
// Streaming nearest-neighbor integer rescaler for 24-bit pixels.
// ----------------------------------------------------------------------------
// Takes one source pixel per request (row padding already stripped) and emits
// scaled pixels. In enlarge mode each pixel goes out scale_factor times and the
// upstream must re-send every source row scale_factor times; in shrink mode a
// pixel is kept only when its row and column are multiples of the factor, at
// most floor(width / factor) per row. The last pixel of each output row has
// row_end set and pad_bytes giving the zero bytes that align the row to 4
// bytes. Rate: one output pixel per cycle while the output is ready; an input
// pixel stays in the job register until its copy counter has sent all of its
// results (scale_factor in enlarge mode, one in shrink mode) on to the output
// register, and a dropped pixel never enters it. The input is taken while a
// finished result still waits at the output register. Register writes are
// taken at any time (ready tied high) and act from the next cycle; a
// frame_start pixel clears the row and column counters before it is used.
`timescale 1ns / 1ps

module pixel_integer_rescaler_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_FACTOR = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    pir_pix_in_if.sink           pix_in,
    pir_pix_out_if.source        pix_out,
    pir_cfg_if.sink              cfg
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int FW = $clog2(MAX_FACTOR + 1);

    logic [WW-1:0]      eff_width;
    logic [FW-1:0]      eff_factor;
    logic               mode;
    logic [FW-1:0]      copies;
    pir_pkg::job_info_t info;
    pir_pkg::pixel_t    in_pix;
    pir_pkg::result_t   out_data;
    logic               in_ready;
    logic               accept;

    // Registers never stall.
    assign cfg.ready = 1'b1;

    pir_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (cfg.valid),
        .wr_addr    (cfg.addr),
        .wr_data    (cfg.data),
        .eff_width  (eff_width),
        .eff_factor (eff_factor),
        .mode       (mode)
    );

    assign in_pix.blue  = pix_in.blue;
    assign in_pix.green = pix_in.green;
    assign in_pix.red   = pix_in.red;

    // Advance counters on every accepted pixel, kept or dropped.
    assign accept       = pix_in.valid && in_ready;
    assign pix_in.ready = in_ready;

    pir_ctrl #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_FACTOR  (MAX_FACTOR)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pix         (in_pix),
        .frame_start (pix_in.frame_start),
        .eff_width   (eff_width),
        .eff_factor  (eff_factor),
        .mode        (mode),
        .copies      (copies),
        .info        (info)
    );

    // Hold the job until its final copy moves into the output register.
    pir_emit #(
        .MAX_FACTOR (MAX_FACTOR)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pix_in.valid),
        .copies     (copies),
        .info       (info),
        .in_ready   (in_ready),
        .out_ready  (pix_out.ready),
        .out_valid  (pix_out.valid),
        .out_data   (out_data)
    );

    assign pix_out.out_blue  = out_data.pix.blue;
    assign pix_out.out_green = out_data.pix.green;
    assign pix_out.out_red   = out_data.pix.red;
    assign pix_out.row_end   = out_data.row_end;
    assign pix_out.pad_bytes = out_data.pad;
    assign pix_out.last      = out_data.last;

endmodule
